// ===== rtl/kcpd_pkg.sv =====
// Shared types and constants for the key click / press detector.
package kcpd_pkg;

    localparam int KEYS_MAX = 4;   // lanes carried on the ports
    localparam int CNT_W    = 16;  // press counter and threshold width
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;
    localparam int KEYS_USE_W = 3;

    typedef enum logic [1:0] {
        MODE_OFF    = 2'd0,
        MODE_SINGLE = 2'd1,
        MODE_DOUBLE = 2'd2,
        MODE_LONG   = 2'd3
    } mode_t;

    // click phase codes
    localparam logic [1:0] PH_IDLE  = 2'd0;
    localparam logic [1:0] PH_FIRST = 2'd1;
    localparam logic [1:0] PH_DONE  = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_THR0     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_THR1     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_THR2     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_THR3     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_POLARITY = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_MODE     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_KEYS     = 3'd6;

endpackage

// ===== rtl/key_click_press_detector.sv =====
// A tick's fire mask is registered in the output stage, or in the skid stage while
// the output is held. One tick word per cycle while the skid is empty; all lanes
// update in parallel from one register stage, with a one-word skid buffer so input
// keeps flowing while a result waits. Reset (aresetn low, synchronous) clears all
// counters, phases and config registers to zero and empties output and skid stages.
module key_click_press_detector #(
    parameter int NUM_KEYS = kcpd_pkg::KEYS_MAX
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [kcpd_pkg::KEYS_MAX-1:0]     s_key_levels,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [kcpd_pkg::KEYS_MAX-1:0]     m_fire_mask,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [kcpd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [kcpd_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import kcpd_pkg::*;

    logic [CNT_W-1:0]      thr_reg [NUM_KEYS];
    logic [KEYS_MAX-1:0]   polarity_reg;
    logic [2*KEYS_MAX-1:0] mode_word_reg;
    logic [KEYS_USE_W-1:0] keys_in_use_reg;

    logic [CNT_W-1:0] cnt_reg  [NUM_KEYS];
    logic [CNT_W-1:0] cnt_next [NUM_KEYS];
    logic [1:0]       ph_reg   [NUM_KEYS];
    logic [1:0]       ph_next  [NUM_KEYS];
    logic [KEYS_MAX-1:0] fire_next;

    logic                out_valid_reg;
    logic [KEYS_MAX-1:0] out_data_reg;
    logic                skid_valid_reg;
    logic [KEYS_MAX-1:0] skid_data_reg;

    logic s_accept;
    logic cfg_write;
    logic out_free;

    assign s_ready   = !skid_valid_reg;
    assign s_accept  = s_valid && s_ready;
    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;
    assign out_free  = !out_valid_reg || m_ready;
    assign m_valid   = out_valid_reg;
    assign m_fire_mask = out_data_reg;

    // per-key lane update, all lanes independent
    always_comb begin
        logic [CNT_W-1:0] cnt;
        logic [CNT_W-1:0] thr;
        logic [1:0]       ph;
        logic             pressed;
        mode_t            mode;
        fire_next = '0;
        for (int k = 0; k < NUM_KEYS; k++) begin
            cnt     = cnt_reg[k];
            thr     = thr_reg[k];
            ph      = ph_reg[k];
            pressed = (s_key_levels[k] == polarity_reg[k]);
            mode    = mode_t'(mode_word_reg[2*k +: 2]);
            if ((KEYS_USE_W'(k) < keys_in_use_reg) && (mode != MODE_OFF)) begin
                if (pressed) begin
                    if (cnt < thr) begin
                        cnt = cnt + CNT_W'(1);
                    end
                    if (cnt >= thr) begin
                        unique case (mode)
                            MODE_LONG: fire_next[k] = 1'b1;
                            MODE_SINGLE: begin
                                if (ph == PH_IDLE) begin
                                    fire_next[k] = 1'b1;
                                    ph = PH_FIRST;
                                end
                            end
                            default: begin
                                if (ph == PH_FIRST) begin
                                    fire_next[k] = 1'b1;
                                    ph = PH_DONE;
                                end
                            end
                        endcase
                    end
                end else if (mode != MODE_DOUBLE) begin
                    cnt = '0;
                    ph  = PH_IDLE;
                end else begin
                    // release gap keeps counting only once armed
                    if (cnt < thr && ph != PH_IDLE) begin
                        cnt = cnt + CNT_W'(1);
                    end
                    if (cnt != '0 && cnt <= thr && ph == PH_IDLE) begin
                        ph = PH_FIRST;
                    end else if (cnt >= thr) begin
                        cnt = '0;
                        ph  = PH_IDLE;
                    end
                end
            end
            cnt_next[k] = cnt;
            ph_next[k]  = ph;
        end
    end

    // configuration and key state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            polarity_reg    <= '0;
            mode_word_reg   <= '0;
            keys_in_use_reg <= '0;
            for (int k = 0; k < NUM_KEYS; k++) begin
                thr_reg[k] <= '0;
                cnt_reg[k] <= '0;
                ph_reg[k]  <= PH_IDLE;
            end
        end else begin
            if (cfg_write) begin
                unique case (cfg_index) inside
                    REG_THR0, REG_THR1, REG_THR2, REG_THR3: begin
                        for (int k = 0; k < NUM_KEYS; k++) begin
                            if (cfg_index == CFG_IDX_W'(k)) begin
                                thr_reg[k] <= cfg_data[CNT_W-1:0];
                            end
                        end
                    end
                    REG_POLARITY: polarity_reg    <= cfg_data[KEYS_MAX-1:0];
                    REG_MODE:     mode_word_reg   <= cfg_data[2*KEYS_MAX-1:0];
                    REG_KEYS:     keys_in_use_reg <= cfg_data[KEYS_USE_W-1:0];
                    default: ;
                endcase
            end
            if (s_accept) begin
                for (int k = 0; k < NUM_KEYS; k++) begin
                    cnt_reg[k] <= cnt_next[k];
                    ph_reg[k]  <= ph_next[k];
                end
            end
        end
    end

    // output register with one-word skid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            if (out_free) begin
                if (skid_valid_reg) begin
                    out_valid_reg  <= 1'b1;
                    skid_valid_reg <= 1'b0;
                end else begin
                    out_valid_reg <= s_accept;
                end
            end else if (s_accept) begin
                skid_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free) begin
            out_data_reg <= skid_valid_reg ? skid_data_reg : fire_next;
        end
        if (!out_free && s_accept) begin
            skid_data_reg <= fire_next;
        end
    end

`ifndef SYNTH
    // skid only fills behind a held output word
    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid word without output word");

    a_blocked_to_skid: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && !out_free) |=> skid_valid_reg)
        else $error("word accepted into stalled output was dropped");

    for (genvar g = 0; g < NUM_KEYS; g++) begin : g_ph_chk
        a_phase_legal: assert property (@(posedge aclk) disable iff (!aresetn)
            (ph_reg[g] == PH_IDLE || ph_reg[g] == PH_FIRST || ph_reg[g] == PH_DONE))
            else $error("illegal click phase");
    end
`endif

endmodule

// ===== sim/key_click_press_detector_check.sv =====
// Checker for the key detector: predicts each tick word's fire mask and compares results.
module key_click_press_detector_check
    import kcpd_pkg::*;
#(
    parameter int NUM_KEYS = KEYS_MAX
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    input  logic                  s_ready,
    input  logic [KEYS_MAX-1:0]   s_key_levels,
    input  logic                  m_valid,
    input  logic                  m_ready,
    input  logic [KEYS_MAX-1:0]   m_fire_mask,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    mismatches,
    output int                    outstanding
);

    logic [CNT_W-1:0]      thr_reg [KEYS_MAX];
    logic [KEYS_MAX-1:0]   pol_reg;
    logic [2*KEYS_MAX-1:0] mode_reg;
    logic [KEYS_USE_W-1:0] keys_reg;

    logic [CNT_W-1:0]      press_cnt [KEYS_MAX];
    logic [1:0]            phase [KEYS_MAX];

    logic [KEYS_MAX-1:0]   fire_expected [$];
    int                    fails = 0;

    // Advances every active key lane by one tick and returns the fire mask.
    function automatic logic [KEYS_MAX-1:0] predict_fire(input logic [KEYS_MAX-1:0] levels);
        logic [KEYS_MAX-1:0] fire;
        int                  active;
        mode_t               md;
        logic                pressed;
        logic [CNT_W-1:0]    thr;
        fire = '0;
        active = (keys_reg > NUM_KEYS) ? NUM_KEYS : int'(keys_reg);
        for (int k = 0; k < KEYS_MAX; k++) begin
            md = mode_t'(mode_reg[2*k +: 2]);
            pressed = (levels[k] == pol_reg[k]);
            thr = thr_reg[k];
            if (k < active && md != MODE_OFF) begin
                if (pressed) begin
                    if (press_cnt[k] < thr)
                        press_cnt[k] = press_cnt[k] + CNT_W'(1);
                    if (press_cnt[k] >= thr) begin
                        case (md)
                            MODE_LONG: fire[k] = 1'b1;
                            MODE_SINGLE: begin
                                if (phase[k] == PH_IDLE) begin
                                    fire[k] = 1'b1;
                                    phase[k] = PH_FIRST;
                                end
                            end
                            MODE_DOUBLE: begin
                                if (phase[k] == PH_FIRST) begin
                                    fire[k] = 1'b1;
                                    phase[k] = PH_DONE;
                                end
                            end
                            default: ;
                        endcase
                    end
                end else if (md != MODE_DOUBLE) begin
                    press_cnt[k] = '0;
                    phase[k] = PH_IDLE;
                end else begin
                    // release between clicks keeps counting toward the window limit
                    if (press_cnt[k] < thr && phase[k] != PH_IDLE)
                        press_cnt[k] = press_cnt[k] + CNT_W'(1);
                    if (press_cnt[k] != 0 && press_cnt[k] <= thr && phase[k] == PH_IDLE) begin
                        phase[k] = PH_FIRST;
                    end else if (press_cnt[k] >= thr) begin
                        press_cnt[k] = '0;
                        phase[k] = PH_IDLE;
                    end
                end
            end
        end
        return fire;
    endfunction

    always @(posedge aclk) begin : track
        logic [KEYS_MAX-1:0] want;
        if (!aresetn) begin
            for (int k = 0; k < KEYS_MAX; k++) begin
                thr_reg[k] = '0;
                press_cnt[k] = '0;
                phase[k] = PH_IDLE;
            end
            pol_reg = '0;
            mode_reg = '0;
            keys_reg = '0;
            fire_expected.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (fire_expected.size() == 0) begin
                    fails++;
                    if (fails <= 10)
                        $display("fire mask %h arrived with no tick word waiting", m_fire_mask);
                end else begin
                    want = fire_expected.pop_front();
                    if (m_fire_mask !== want) begin
                        fails++;
                        if (fails <= 10)
                            $display("fire mask mismatch: expected %h, got %h", want, m_fire_mask);
                    end
                end
            end
            if (s_valid && s_ready)
                fire_expected.push_back(predict_fire(s_key_levels));
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_THR0, REG_THR1, REG_THR2, REG_THR3: thr_reg[cfg_index[1:0]] = cfg_data;
                    REG_POLARITY: pol_reg = cfg_data[KEYS_MAX-1:0];
                    REG_MODE:     mode_reg = cfg_data[2*KEYS_MAX-1:0];
                    REG_KEYS:     keys_reg = cfg_data[KEYS_USE_W-1:0];
                    default: ;
                endcase
            end
        end
        mismatches <= fails;
        outstanding <= fire_expected.size();
    end

endmodule

// ===== sim/key_click_press_detector_test.sv =====
// Testbench top for the key detector: clock, reset, stimulus and verdict.
module key_click_press_detector_test;
    import kcpd_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int SINK_HOLD   = 200;
    localparam int TAIL_CYCLES = 4;
    localparam int PHASES      = 13;
    localparam int PHASE_ITEMS = 50;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic [KEYS_MAX-1:0]   s_key_levels = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic [KEYS_MAX-1:0]   m_fire_mask;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    int                    mismatches;
    int                    outstanding;

    bit                    pace_on = 1'b1;
    int                    holds_asked = 0;
    int                    holds_done = 0;
    int                    run_left [KEYS_MAX];
    logic [KEYS_MAX-1:0]   cur_lv = '0;

    always #1 aclk = ~aclk;

    key_click_press_detector i_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_key_levels (s_key_levels),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_fire_mask  (m_fire_mask),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    key_click_press_detector_check i_check (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_key_levels (s_key_levels),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_fire_mask  (m_fire_mask),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .mismatches   (mismatches),
        .outstanding  (outstanding)
    );

    // mostly short gaps, now and then a long one
    function automatic int gap_len();
        return ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(8, 30);
    endfunction

    function automatic logic [CNT_W-1:0] pick_threshold();
        int r;
        r = $urandom_range(0, 19);
        if (r < 14)
            return CNT_W'($urandom_range(0, 6));
        else if (r < 16)
            return 16'hFFFF;
        else if (r < 18)
            return CNT_W'($urandom_range(7, 40));
        return CNT_W'($urandom);
    endfunction

    function automatic logic [KEYS_USE_W-1:0] pick_keys();
        return ($urandom_range(0, 3) == 0) ? KEYS_USE_W'($urandom_range(0, 7)) : 3'd4;
    endfunction

    // Each key holds its level for a run, so presses and releases look like real clicks.
    function automatic logic [KEYS_MAX-1:0] next_levels(input bit shaped);
        for (int k = 0; k < KEYS_MAX; k++) begin
            if (run_left[k] == 0) begin
                cur_lv[k] = ~cur_lv[k];
                run_left[k] = ($urandom_range(0, 7) == 0) ? $urandom_range(6, 20)
                                                          : $urandom_range(1, 5);
            end
            run_left[k]--;
        end
        return shaped ? cur_lv : KEYS_MAX'($urandom);
    endfunction

    task automatic send_tick(input logic [KEYS_MAX-1:0] lv);
        int gap;
        gap = (pace_on && $urandom_range(0, 2) == 0) ? gap_len() : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_key_levels <= lv;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    // cfg_valid stays high; the caller lowers it after the last write
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
    endtask

    task automatic load_config(input logic [CNT_W-1:0] t0, input logic [CNT_W-1:0] t1,
                               input logic [CNT_W-1:0] t2, input logic [CNT_W-1:0] t3,
                               input logic [KEYS_MAX-1:0] pol,
                               input logic [2*KEYS_MAX-1:0] modes,
                               input logic [KEYS_USE_W-1:0] keys);
        logic [CFG_DATA_W-1:0] junk;
        junk = CFG_DATA_W'($urandom);
        write_reg(REG_THR0, t0);
        write_reg(REG_THR1, t1);
        write_reg(REG_THR2, t2);
        write_reg(REG_THR3, t3);
        write_reg(REG_POLARITY, {junk[CFG_DATA_W-1:KEYS_MAX], pol});
        write_reg(REG_MODE, {junk[CFG_DATA_W-1:2*KEYS_MAX], modes});
        write_reg(REG_KEYS, {junk[CFG_DATA_W-1:KEYS_USE_W], keys});
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (outstanding != 0) @(negedge aclk);
    endtask

    initial begin : sink
        int stall_left;
        stall_left = 0;
        forever begin
            @(negedge aclk);
            if (stall_left > 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else if (holds_done != holds_asked) begin
                holds_done++;
                stall_left = SINK_HOLD - 1;
                m_ready <= 1'b0;
            end else if (pace_on && $urandom_range(0, 3) == 0) begin
                stall_left = gap_len() - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    initial begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $display("FAILURE");
        $finish;
    end

    initial begin : stimulus
        logic [KEYS_MAX-1:0] seq_a [13];
        logic [KEYS_MAX-1:0] seq_b [10];
        bit shaped;
        seq_a = '{4'h0, 4'hF, 4'h5, 4'h5, 4'h5, 4'hA, 4'h8, 4'hA, 4'hA, 4'h0, 4'h4, 4'h4, 4'h4};
        seq_b = '{4'h5, 4'h4, 4'hF, 4'h0, 4'hF, 4'h1, 4'h0, 4'hE, 4'h8, 4'hF};

        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // reset config: no key in use, nothing fires
        send_tick(4'h0);
        send_tick(4'hF);
        drain();

        // zero and full thresholds, every mode, key count above the lane count
        load_config(16'd0, 16'd3, 16'd2, 16'hFFFF, 4'b0101,
                    {MODE_OFF, MODE_LONG, MODE_DOUBLE, MODE_SINGLE}, 3'd7);
        write_reg(REG_UNUSED, 16'hFFFF);
        cfg_valid <= 1'b0;
        foreach (seq_a[i]) send_tick(seq_a[i]);
        drain();

        // key 2 still pressed while its threshold drops below the count;
        // double click with zero threshold; key 3 out of use
        load_config(16'd0, 16'hFFFF, 16'd1, 16'd5, 4'b1111,
                    {MODE_LONG, MODE_SINGLE, MODE_LONG, MODE_DOUBLE}, 3'd3);
        cfg_valid <= 1'b0;
        foreach (seq_b[i]) send_tick(seq_b[i]);

        for (int p = 0; p < PHASES; p++) begin
            drain();
            if (p == 0)
                load_config(16'd0, 16'd0, 16'd0, 16'd0, 4'b0000, 8'hFF, 3'd4);
            else if (p == 1)
                load_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 4'b1111,
                            (2*KEYS_MAX)'($urandom), 3'd7);
            else
                load_config(pick_threshold(), pick_threshold(), pick_threshold(),
                            pick_threshold(), KEYS_MAX'($urandom),
                            (2*KEYS_MAX)'($urandom), pick_keys());
            cfg_valid <= 1'b0;
            pace_on = (p % 4 != 3) && (p != 2);
            shaped = ($urandom_range(0, 4) != 0);
            // long receiver hold-off while ticks keep coming, to fill the block up
            if (p == 2)
                holds_asked++;
            for (int i = 0; i < PHASE_ITEMS; i++)
                send_tick(next_levels(shaped));
        end

        drain();
        repeat (TAIL_CYCLES) @(negedge aclk);
        if (mismatches == 0 && outstanding == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
